### hw/rtl/salc_pkg.sv
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types and constants for the set-associative LRU cache tag model.
// ----------------------------------------------------------------------------
package salc_pkg;

  localparam int TOTAL_LINES_DEF = 512;
  localparam int LINE_BYTES_DEF  = 32;
  localparam int ADDR_BITS_DEF   = 32;

  localparam int WAYS_W   = 4;
  localparam int POLICY_W = 2;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam logic [WAYS_W-1:0] WAYS_RST = 4'd1;

  typedef enum logic [POLICY_W-1:0] {
    POL_PLAIN     = 2'd0,
    POL_NO_WALLOC = 2'd1,
    POL_NEXT_LINE = 2'd2,
    POL_PF_MISS   = 2'd3
  } policy_t;

  typedef enum logic {
    REG_WAYS   = 1'b0,
    REG_POLICY = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [WAYS_W-1:0] wl_eff;
    policy_t           policy;
    logic              flush;
  } salc_cfg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_FINISH,
    ST_DONE
  } state_t;

endpackage

### hw/rtl/set_assoc_lru_cache_with_prefetch_top.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_with_prefetch_top
// Tag-only set-associative cache with true LRU ranks and next-line prefetch.
// ----------------------------------------------------------------------------
// A lookup pass runs SETUP, a serial SCAN of the ways, DECIDE and, when ranks
// change, an UPDATE pass over the ways; FINISH then starts a second pass for a
// prefetch or goes to DONE. One access at a time: busy holds
// start off until the result beat, which the receiver cannot stall.
// Reset and any ways_log2 write run a clearing pass over all TOTAL_LINES entries
// (512 by default) with busy high.
module set_assoc_lru_cache_with_prefetch_top #(
  parameter int TOTAL_LINES = salc_pkg::TOTAL_LINES_DEF,
  parameter int LINE_BYTES  = salc_pkg::LINE_BYTES_DEF,
  parameter int ADDR_BITS   = salc_pkg::ADDR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_op,
  input  logic [31:0]                   in_address,
  output logic                          out_valid,
  output logic                          out_hit,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [salc_pkg::CFG_AW-1:0]   paddr,
  input  logic [salc_pkg::CFG_DW-1:0]   pwdata,
  output logic [salc_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int IDXW  = $clog2(TOTAL_LINES);
  localparam int LINEW = ADDR_BITS - $clog2(LINE_BYTES);

  salc_pkg::salc_cfg_t cfg;

  logic             tag_we;
  logic [IDXW-1:0]  tag_waddr;
  logic [LINEW-1:0] tag_wdata;
  logic [IDXW-1:0]  tag_raddr;
  logic [LINEW-1:0] tag_rdata;
  logic             rank_we;
  logic [IDXW-1:0]  rank_waddr;
  logic [IDXW-1:0]  rank_wdata;
  logic [IDXW-1:0]  rank_raddr;
  logic [IDXW-1:0]  rank_rdata;

  salc_cfg #(
    .TOTAL_LINES(TOTAL_LINES)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  salc_ram #(
    .WIDTH(LINEW),
    .DEPTH(TOTAL_LINES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  salc_ram #(
    .WIDTH(IDXW),
    .DEPTH(TOTAL_LINES)
  ) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (rank_waddr),
    .wdata (rank_wdata),
    .raddr (rank_raddr),
    .rdata (rank_rdata)
  );

  salc_seq #(
    .TOTAL_LINES(TOTAL_LINES),
    .LINE_BYTES (LINE_BYTES),
    .ADDR_BITS  (ADDR_BITS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_op      (in_op),
    .in_address (in_address),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_hit    (out_hit),
    .cfg        (cfg),
    .tag_we     (tag_we),
    .tag_waddr  (tag_waddr),
    .tag_wdata  (tag_wdata),
    .tag_raddr  (tag_raddr),
    .tag_rdata  (tag_rdata),
    .rank_we    (rank_we),
    .rank_waddr (rank_waddr),
    .rank_wdata (rank_wdata),
    .rank_raddr (rank_raddr),
    .rank_rdata (rank_rdata)
  );

endmodule

### hw/rtl/salc_ram.sv
// ----------------------------------------------------------------------------
// salc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/salc_cfg.sv
// ----------------------------------------------------------------------------
// salc_cfg
// APB register file: associativity and policy, flush pulse on ways write.
// ----------------------------------------------------------------------------
module salc_cfg #(
  parameter int TOTAL_LINES = salc_pkg::TOTAL_LINES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [salc_pkg::CFG_AW-1:0]   paddr,
  input  logic [salc_pkg::CFG_DW-1:0]   pwdata,
  output logic [salc_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  output salc_pkg::salc_cfg_t           cfg
);

  localparam int IDXW = $clog2(TOTAL_LINES);
  localparam logic [salc_pkg::WAYS_W-1:0] WL_MAX = salc_pkg::WAYS_W'(IDXW);

  logic [salc_pkg::WAYS_W-1:0] ways_r;
  salc_pkg::policy_t           policy_r;
  logic                        flush_r;
  logic                        wr_en;
  salc_pkg::reg_idx_t          idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = salc_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ways_r   <= salc_pkg::WAYS_RST;
      policy_r <= salc_pkg::POL_PLAIN;
      flush_r  <= 1'b0;
    end else begin
      flush_r <= 1'b0;
      if (wr_en) begin
        unique case (idx)
          salc_pkg::REG_WAYS: begin
            ways_r  <= pwdata[salc_pkg::WAYS_W-1:0];
            flush_r <= 1'b1;
          end
          salc_pkg::REG_POLICY: begin
            policy_r <= salc_pkg::policy_t'(pwdata[salc_pkg::POLICY_W-1:0]);
          end
        endcase
      end
    end
  end

  always_comb begin
    unique case (idx)
      salc_pkg::REG_WAYS:   prdata = salc_pkg::CFG_DW'(ways_r);
      salc_pkg::REG_POLICY: prdata = salc_pkg::CFG_DW'(policy_r);
    endcase
  end

  assign cfg.wl_eff = (ways_r > WL_MAX) ? WL_MAX : ways_r;
  assign cfg.policy = policy_r;
  assign cfg.flush  = flush_r;

endmodule

### hw/rtl/salc_seq.sv
// ----------------------------------------------------------------------------
// salc_seq
// Sequencer and shared way unit: serial tag/rank scan, then rank update pass when needed.
// ----------------------------------------------------------------------------
module salc_seq #(
  parameter int TOTAL_LINES = salc_pkg::TOTAL_LINES_DEF,
  parameter int LINE_BYTES  = salc_pkg::LINE_BYTES_DEF,
  parameter int ADDR_BITS   = salc_pkg::ADDR_BITS_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              start,
  input  logic                                              in_op,
  input  logic [31:0]                                       in_address,
  output logic                                              busy,
  output logic                                              out_valid,
  output logic                                              out_hit,
  input  salc_pkg::salc_cfg_t                               cfg,
  output logic                                              tag_we,
  output logic [$clog2(TOTAL_LINES)-1:0]                    tag_waddr,
  output logic [ADDR_BITS-$clog2(LINE_BYTES)-1:0]           tag_wdata,
  output logic [$clog2(TOTAL_LINES)-1:0]                    tag_raddr,
  input  logic [ADDR_BITS-$clog2(LINE_BYTES)-1:0]           tag_rdata,
  output logic                                              rank_we,
  output logic [$clog2(TOTAL_LINES)-1:0]                    rank_waddr,
  output logic [$clog2(TOTAL_LINES)-1:0]                    rank_wdata,
  output logic [$clog2(TOTAL_LINES)-1:0]                    rank_raddr,
  input  logic [$clog2(TOTAL_LINES)-1:0]                    rank_rdata
);

  localparam int IDXW   = $clog2(TOTAL_LINES);
  localparam int OFF    = $clog2(LINE_BYTES);
  localparam int LINEW  = ADDR_BITS - OFF;
  localparam int LINEXW = (LINEW > IDXW) ? LINEW : IDXW;
  localparam int CNTW   = IDXW + 1;

  salc_pkg::state_t state_r, state_nxt;
  logic [CNTW-1:0]  j_r, j_nxt;
  logic             op_r, op_nxt;
  logic             pf_r, pf_nxt;
  logic [LINEW-1:0] line_r, line_nxt;
  logic [LINEW-1:0] tag_r, tag_nxt;
  logic [IDXW-1:0]  base_r, base_nxt;
  logic             found_r, found_nxt;
  logic [IDXW-1:0]  hit_way_r, hit_way_nxt;
  logic [IDXW-1:0]  hit_rank_r, hit_rank_nxt;
  logic [IDXW-1:0]  lru_way_r, lru_way_nxt;
  logic [IDXW-1:0]  sel_way_r, sel_way_nxt;
  logic [IDXW-1:0]  thresh_r, thresh_nxt;
  logic             hit_r, hit_nxt;

  logic [ADDR_BITS-1:0]         addr_full;
  logic [LINEXW-1:0]            line_x;
  logic [salc_pkg::WAYS_W-1:0]  sh;
  logic [CNTW-1:0]              ways_c;
  logic [IDXW-1:0]              top_c;
  logic [IDXW-1:0]              way_w;
  logic                         may_fill;
  logic                         do_pf;

  assign addr_full = ADDR_BITS'(in_address);
  assign line_x    = LINEXW'(line_r);
  assign sh        = salc_pkg::WAYS_W'(IDXW) - cfg.wl_eff;
  assign ways_c    = CNTW'(1) << cfg.wl_eff;
  assign top_c     = IDXW'(ways_c - CNTW'(1));
  assign way_w     = IDXW'(j_r - CNTW'(1));
  assign may_fill  = pf_r || !(cfg.policy == salc_pkg::POL_NO_WALLOC && op_r);
  assign do_pf     = !pf_r && ((cfg.policy == salc_pkg::POL_NEXT_LINE) ||
                               (cfg.policy == salc_pkg::POL_PF_MISS && !found_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= salc_pkg::ST_CLEAR;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      j_r     <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    pf_r       <= pf_nxt;
    line_r     <= line_nxt;
    tag_r      <= tag_nxt;
    base_r     <= base_nxt;
    found_r    <= found_nxt;
    hit_way_r  <= hit_way_nxt;
    hit_rank_r <= hit_rank_nxt;
    lru_way_r  <= lru_way_nxt;
    sel_way_r  <= sel_way_nxt;
    thresh_r   <= thresh_nxt;
    hit_r      <= hit_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    j_nxt        = j_r;
    op_nxt       = op_r;
    pf_nxt       = pf_r;
    line_nxt     = line_r;
    tag_nxt      = tag_r;
    base_nxt     = base_r;
    found_nxt    = found_r;
    hit_way_nxt  = hit_way_r;
    hit_rank_nxt = hit_rank_r;
    lru_way_nxt  = lru_way_r;
    sel_way_nxt  = sel_way_r;
    thresh_nxt   = thresh_r;
    hit_nxt      = hit_r;

    tag_we     = 1'b0;
    tag_waddr  = base_r | lru_way_r;
    tag_wdata  = tag_r;
    rank_we    = 1'b0;
    rank_waddr = base_r | way_w;
    rank_wdata = rank_rdata;
    tag_raddr  = base_r | j_r[IDXW-1:0];
    rank_raddr = base_r | j_r[IDXW-1:0];

    unique case (state_r)
      salc_pkg::ST_CLEAR: begin
        tag_we     = 1'b1;
        tag_waddr  = j_r[IDXW-1:0];
        tag_wdata  = '0;
        rank_we    = 1'b1;
        rank_waddr = j_r[IDXW-1:0];
        rank_wdata = j_r[IDXW-1:0] & top_c;
        if (j_r[IDXW-1:0] == '1) begin
          state_nxt = salc_pkg::ST_IDLE;
          j_nxt     = '0;
        end else begin
          j_nxt = j_r + CNTW'(1);
        end
      end

      salc_pkg::ST_IDLE: begin
        if (start) begin
          op_nxt    = in_op;
          pf_nxt    = 1'b0;
          line_nxt  = LINEW'(addr_full >> OFF);
          state_nxt = salc_pkg::ST_SETUP;
        end
      end

      salc_pkg::ST_SETUP: begin
        tag_nxt   = LINEW'(line_r >> sh);
        base_nxt  = line_x[IDXW-1:0] << cfg.wl_eff;
        found_nxt = 1'b0;
        j_nxt     = '0;
        state_nxt = salc_pkg::ST_SCAN;
      end

      salc_pkg::ST_SCAN: begin
        if (j_r != '0) begin
          if (!found_r && tag_rdata == tag_r) begin
            found_nxt    = 1'b1;
            hit_way_nxt  = way_w;
            hit_rank_nxt = rank_rdata;
          end
          if (rank_rdata == '0) begin
            lru_way_nxt = way_w;
          end
        end
        if (j_r == ways_c) begin
          state_nxt = salc_pkg::ST_DECIDE;
        end else begin
          j_nxt = j_r + CNTW'(1);
        end
      end

      salc_pkg::ST_DECIDE: begin
        j_nxt = '0;
        priority if (found_r && hit_rank_r == top_c) begin
          state_nxt = salc_pkg::ST_FINISH;
        end else if (found_r && hit_rank_r != '0) begin
          sel_way_nxt = hit_way_r;
          thresh_nxt  = hit_rank_r;
          state_nxt   = salc_pkg::ST_UPDATE;
        end else if (!found_r && !may_fill) begin
          state_nxt = salc_pkg::ST_FINISH;
        end else begin
          tag_we      = 1'b1;
          sel_way_nxt = lru_way_r;
          thresh_nxt  = '0;
          state_nxt   = salc_pkg::ST_UPDATE;
        end
      end

      salc_pkg::ST_UPDATE: begin
        if (j_r != '0) begin
          rank_we = 1'b1;
          priority if (way_w == sel_way_r) begin
            rank_wdata = top_c;
          end else if (rank_rdata > thresh_r) begin
            rank_wdata = rank_rdata - IDXW'(1);
          end else begin
            rank_wdata = rank_rdata;
          end
        end
        if (j_r == ways_c) begin
          state_nxt = salc_pkg::ST_FINISH;
        end else begin
          j_nxt = j_r + CNTW'(1);
        end
      end

      salc_pkg::ST_FINISH: begin
        if (!pf_r) begin
          hit_nxt = found_r;
        end
        if (do_pf) begin
          pf_nxt    = 1'b1;
          line_nxt  = line_r + LINEW'(1);
          state_nxt = salc_pkg::ST_SETUP;
        end else begin
          state_nxt = salc_pkg::ST_DONE;
        end
      end

      salc_pkg::ST_DONE: begin
        state_nxt = salc_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = salc_pkg::ST_IDLE;
      end
    endcase

    if (cfg.flush) begin
      state_nxt = salc_pkg::ST_CLEAR;
      j_nxt     = '0;
    end
  end

  assign busy      = (state_r != salc_pkg::ST_IDLE) || cfg.flush;
  assign out_valid = (state_r == salc_pkg::ST_DONE);
  assign out_hit   = hit_r;

endmodule

### tb/salc_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// salc_scoreboard_pkg
// Tag and LRU-rank shadow of the cache, used to predict the hit bit of every
// accepted access and to check each result beat against the oldest one.
// ----------------------------------------------------------------------------
package salc_scoreboard_pkg;

  localparam int LINES      = salc_pkg::TOTAL_LINES_DEF;
  localparam int OFF_BITS   = $clog2(salc_pkg::LINE_BYTES_DEF);
  localparam int MAX_WL     = $clog2(salc_pkg::TOTAL_LINES_DEF);
  localparam int MAX_REPORT = 10;

  class cache_hit_scoreboard;
    logic [31:0]                 line_tag [LINES];
    int unsigned                 lru_rank [LINES];
    logic [salc_pkg::WAYS_W-1:0] ways_reg;
    salc_pkg::policy_t           pol_reg;
    bit                          pending_hits [$];
    int                          errors;

    function new();
      ways_reg = salc_pkg::WAYS_RST;
      pol_reg  = salc_pkg::POL_PLAIN;
      errors   = 0;
      flush();
    endfunction

    function int unsigned eff_wl();
      return (ways_reg > MAX_WL) ? MAX_WL : ways_reg;
    endfunction

    function void flush();
      int unsigned mask;
      mask = (1 << eff_wl()) - 1;
      for (int i = 0; i < LINES; i++) begin
        line_tag[i] = '0;
        lru_rank[i] = i & mask;
      end
    endfunction

    function void write_reg(salc_pkg::reg_idx_t idx, logic [31:0] data);
      case (idx)
        salc_pkg::REG_WAYS: begin
          ways_reg = data[salc_pkg::WAYS_W-1:0];
          flush();
        end
        salc_pkg::REG_POLICY: pol_reg = salc_pkg::policy_t'(data[salc_pkg::POLICY_W-1:0]);
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(salc_pkg::reg_idx_t idx);
      return (idx == salc_pkg::REG_WAYS) ? 32'(ways_reg) : 32'(pol_reg);
    endfunction

    // one line lookup with LRU update; returns hit
    function bit probe_line(logic [31:0] addr, bit may_fill);
      int unsigned wl, setb, ways, top, base, e, hit_way, lru_way, r;
      logic [31:0] set_idx, tag;
      bit hit;
      wl      = eff_wl();
      setb    = MAX_WL - wl;
      ways    = 1 << wl;
      top     = ways - 1;
      set_idx = (addr >> OFF_BITS) & ((32'd1 << setb) - 1);
      tag     = addr >> (OFF_BITS + setb);
      base    = set_idx << wl;
      hit     = 1'b0;
      hit_way = 0;
      lru_way = 0;
      for (int unsigned j = 0; j < ways; j++) begin
        e = (base + j) % LINES;
        if (!hit && line_tag[e] == tag) begin
          hit     = 1'b1;
          hit_way = j;
        end
        if (lru_rank[e] == 0) lru_way = j;
      end
      if (hit) begin
        r = lru_rank[(base + hit_way) % LINES];
        if (r == top) return 1'b1;
        if (r != 0) begin
          for (int unsigned j = 0; j < ways; j++) begin
            e = (base + j) % LINES;
            if (j == hit_way) lru_rank[e] = top;
            else if (lru_rank[e] > r) lru_rank[e]--;
          end
          return 1'b1;
        end
      end else if (!may_fill) begin
        return 1'b0;
      end
      for (int unsigned j = 0; j < ways; j++) begin
        e = (base + j) % LINES;
        if (j == lru_way) begin
          lru_rank[e] = top;
          line_tag[e] = tag;
        end else if (lru_rank[e] > 0) begin
          lru_rank[e]--;
        end
      end
      return hit;
    endfunction

    function void note_access(bit is_store, logic [31:0] addr);
      bit hit;
      hit = probe_line(addr, !(pol_reg == salc_pkg::POL_NO_WALLOC && is_store));
      if (pol_reg == salc_pkg::POL_NEXT_LINE || (pol_reg == salc_pkg::POL_PF_MISS && !hit))
        void'(probe_line(addr + salc_pkg::LINE_BYTES_DEF, 1'b1));
      pending_hits.insert(pending_hits.size(), hit);
    endfunction

    function void mismatch(string what, logic [31:0] exp, logic [31:0] act);
      errors++;
      if (errors <= MAX_REPORT)
        $display("mismatch %s: expected %0h actual %0h", what, exp, act);
    endfunction

    function void check_hit(logic act);
      bit exp;
      if (pending_hits.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORT) $display("result beat with no access pending");
      end else begin
        exp = pending_hits.pop_front();
        if (act !== exp) mismatch("hit", 32'(exp), 32'(act));
      end
    endfunction
  endclass

endpackage

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives load/store accesses and register writes into the LRU tag cache and
// checks every hit beat against a shadow model, over several associativity
// and policy settings, with random start idling.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam bit OP_LOAD    = 1'b0;
  localparam bit OP_STORE   = 1'b1;
  localparam int WDOG_LIMIT = 40000;
  localparam int NPHASE     = 14;
  localparam int TAIL_ITEMS = 150;

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic                        in_op;
  logic [31:0]                 in_address;
  logic                        out_valid;
  logic                        out_hit;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [salc_pkg::CFG_AW-1:0] paddr;
  logic [salc_pkg::CFG_DW-1:0] pwdata;
  logic [salc_pkg::CFG_DW-1:0] prdata;
  logic                        pready;

  salc_scoreboard_pkg::cache_hit_scoreboard sb;
  int                  wdog_cnt = 0;
  int                  idle_rate;
  logic [31:0]         last_addr;

  set_assoc_lru_cache_with_prefetch_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_address(in_address),
    .out_valid(out_valid), .out_hit(out_hit),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_hit(out_hit);
      if (start && !busy) sb.note_access(in_op, in_address);
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (psel && penable && pready)) begin
      wdog_cnt <= 0;
    end else if (wdog_cnt >= WDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      wdog_cnt <= wdog_cnt + 1;
    end
  end

  task automatic cfg_write(salc_pkg::reg_idx_t idx, logic [3:0] value);
    logic [31:0] data;
    data = ($urandom & ~32'hF) | 32'(value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic cfg_check(salc_pkg::reg_idx_t idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== sb.reg_value(idx))
      sb.mismatch(idx == salc_pkg::REG_WAYS ? "ways_log2 read" : "policy read",
                  sb.reg_value(idx), prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_access(bit op, logic [31:0] addr);
    if (idle_rate != 0 && $urandom_range(0, 3) < idle_rate) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    start      <= 1'b1;
    in_op      <= op;
    in_address <= addr;
    last_addr   = addr;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending_hits.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic set_cfg(logic [3:0] wl, salc_pkg::policy_t pol);
    drain();
    cfg_write(salc_pkg::REG_WAYS, wl);
    cfg_check(salc_pkg::REG_WAYS);
    cfg_write(salc_pkg::REG_POLICY, 4'(pol));
    cfg_check(salc_pkg::REG_POLICY);
  endtask

  function automatic logic [31:0] pick_address(int unsigned wl);
    int unsigned mode, pool_hi;
    logic [31:0] a;
    mode    = $urandom_range(0, 19);
    pool_hi = (wl <= 4) ? (1 << wl) + 3 : 40;
    a = ($urandom_range(0, pool_hi) << 14)
        | ($urandom_range(0, 3) << salc_scoreboard_pkg::OFF_BITS)
        | $urandom_range(0, 31);
    if (mode < 12) return a;
    if (mode < 14) return last_addr + salc_pkg::LINE_BYTES_DEF;
    if (mode < 15) return last_addr;
    if (mode < 17) return ~a;
    return $urandom;
  endfunction

  int unsigned phase_wl [NPHASE] = '{2, 0, 3, 1, 4, 9, 2, 5, 3, 1, 15, 0, 4, 2};

  initial begin
    int unsigned wl, n, sent, total;
    sb         = new();
    idle_rate  = 0;
    last_addr  = '0;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_op      = OP_LOAD;
    in_address = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values, tag 0 present without valid bits
    cfg_check(salc_pkg::REG_WAYS);
    cfg_check(salc_pkg::REG_POLICY);
    send_access(OP_LOAD,  32'h0000_0000);
    send_access(OP_STORE, 32'hFFFF_FFFF);
    send_access(OP_LOAD,  32'hFFFF_FFFF);
    send_access(OP_LOAD,  32'h0000_4000);
    send_access(OP_LOAD,  32'h0000_0000);
    send_access(OP_STORE, 32'h1234_5678);

    // store miss without allocation; policy write keeps contents
    drain();
    cfg_write(salc_pkg::REG_POLICY, 4'(salc_pkg::POL_NO_WALLOC));
    send_access(OP_LOAD,  32'h1234_5678);
    send_access(OP_STORE, 32'hABCD_EF00);
    send_access(OP_STORE, 32'hABCD_EF00);
    send_access(OP_LOAD,  32'hABCD_EF00);
    send_access(OP_STORE, 32'hABCD_EF00);

    // next-line prefetch wrapping past the top of the address space
    drain();
    cfg_write(salc_pkg::REG_POLICY, 4'(salc_pkg::POL_NEXT_LINE));
    send_access(OP_LOAD,  32'hFFFF_FFE0);
    send_access(OP_LOAD,  32'h0000_0000);
    send_access(OP_STORE, 32'h0000_0020);

    drain();
    cfg_write(salc_pkg::REG_POLICY, 4'(salc_pkg::POL_PF_MISS));
    send_access(OP_LOAD,  32'h5555_5540);
    send_access(OP_LOAD,  32'h5555_5560);

    set_cfg(4'd0, salc_pkg::POL_PLAIN);
    send_access(OP_LOAD,  32'h0000_4000);
    send_access(OP_LOAD,  32'h0000_0000);

    set_cfg(4'd9, salc_pkg::POL_PLAIN);
    send_access(OP_LOAD,  32'hFFFF_FFFF);
    send_access(OP_STORE, 32'h0000_0020);

    // associativity above the line count acts as fully associative
    set_cfg(4'd15, salc_pkg::POL_NEXT_LINE);
    send_access(OP_LOAD,  32'hAAAA_AAAA);
    send_access(OP_STORE, 32'h0000_0000);

    total = 0;
    for (int p = 0; p < NPHASE; p++)
      total += (phase_wl[p] >= 9) ? 30 : ((phase_wl[p] >= 5) ? 60 : 105);
    sent = 0;
    for (int p = 0; p < NPHASE; p++) begin
      wl = (phase_wl[p] > salc_scoreboard_pkg::MAX_WL) ?
           salc_scoreboard_pkg::MAX_WL : phase_wl[p];
      n  = (wl >= 9) ? 30 : ((wl >= 5) ? 60 : 105);
      set_cfg(4'(phase_wl[p]), salc_pkg::policy_t'(p % 4));
      idle_rate = $urandom_range(0, 2);
      for (int half = 0; half < 2; half++) begin
        if (half == 1) begin
          drain();
          cfg_write(salc_pkg::REG_POLICY, 4'($urandom_range(0, 3)));
        end
        for (int k = 0; k < n / 2; k++) begin
          if (sent + TAIL_ITEMS >= total) idle_rate = 0;
          send_access(1'($urandom_range(0, 1)), pick_address(wl));
          sent++;
        end
      end
    end

    drain();
    repeat (60) @(posedge clk);
    if (sb.errors == 0 && sb.pending_hits.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
